// ===== rtl/core/cptu_pkg.sv =====
// Shared types, codes and constants for the cascaded prescaled timer unit.
// No dependencies; used by cptu_timer and cascaded_prescaled_timer_unit.
`default_nettype none

package cptu_pkg;

   // Timer count and defaults
   localparam int NUM_TIMERS_DEF = 4;
   localparam int CNT_W          = 16;
   localparam int PRESC_W        = 10;
   localparam int CTL_W          = 8;
   localparam int FLAG_W         = 4;
   localparam int SEL_W          = 2;

   localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

   // Control byte bit positions
   localparam int CTL_CASCADE_BIT = 2;
   localparam int CTL_IRQ_BIT     = 6;
   localparam int CTL_ENABLE_BIT  = 7;

   // Request action codes
   typedef enum logic [1:0] {
      ACT_TICK       = 2'd0,
      ACT_WR_RELOAD  = 2'd1,
      ACT_WR_CONTROL = 2'd2,
      ACT_RD_COUNTER = 2'd3
   } action_type;

   // Per-timer command, decoded from one request
   typedef struct packed {
      logic tick;
      logic wr_reload;
      logic wr_control;
   } timer_cmd_type;

   // Prescaler terminal value for a prescale select
   function automatic logic [PRESC_W-1:0] presc_match(input logic [1:0] psel);
      logic [PRESC_W-1:0] m;
      case (psel)
         2'd0:    m = 10'd0;
         2'd1:    m = 10'd63;
         2'd2:    m = 10'd255;
         2'd3:    m = 10'd1023;
         default: m = 10'd0;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cptu_timer.sv =====
// One 16-bit timer channel: counter, reload, control byte and prescaler.
// Depends on cptu_pkg.
`default_nettype none

module cptu_timer (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire cptu_pkg::timer_cmd_type     cmd,
   input  wire logic [cptu_pkg::CNT_W-1:0]  write_data,
   input  wire logic                        chain_en,
   input  wire logic                        chain_in,
   output logic                             overflow,
   output logic                             irq,
   output logic [cptu_pkg::CNT_W-1:0]       count
);

   logic [cptu_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [cptu_pkg::CNT_W-1:0]   reload_ff, reload_in;
   logic [cptu_pkg::CTL_W-1:0]   ctrl_ff, ctrl_in;
   logic [cptu_pkg::PRESC_W-1:0] presc_ff, presc_in;

   logic enable, cascade, presc_fire, count_step, enable_rise;

   // Decode control and step conditions
   assign enable      = ctrl_ff[cptu_pkg::CTL_ENABLE_BIT];
   assign cascade     = ctrl_ff[cptu_pkg::CTL_CASCADE_BIT] && chain_en;
   assign presc_fire  = presc_ff >= cptu_pkg::presc_match(ctrl_ff[1:0]);
   assign count_step  = cmd.tick && enable && (cascade ? chain_in : presc_fire);
   assign overflow    = count_step && (count_ff == cptu_pkg::CNT_MAX);
   assign irq         = overflow && ctrl_ff[cptu_pkg::CTL_IRQ_BIT];
   assign enable_rise = cmd.wr_control && write_data[cptu_pkg::CTL_ENABLE_BIT] && !enable;
   assign count       = count_ff;

   // Next state
   always_comb begin
      count_in  = count_ff;
      presc_in  = presc_ff;
      reload_in = cmd.wr_reload ? write_data : reload_ff;
      ctrl_in   = cmd.wr_control ? write_data[cptu_pkg::CTL_W-1:0] : ctrl_ff;
      if (enable_rise) begin
         count_in = reload_ff;
         presc_in = '0;
      end else if (cmd.tick && enable) begin
         if (cascade) begin
            if (chain_in) begin
               presc_in = '0;
            end
         end else if (presc_fire) begin
            presc_in = '0;
         end else begin
            presc_in = presc_ff + 1'b1;
         end
         if (count_step) begin
            count_in = overflow ? reload_ff : count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         reload_ff <= '0;
         ctrl_ff   <= '0;
         presc_ff  <= '0;
      end else begin
         count_ff  <= count_in;
         reload_ff <= reload_in;
         ctrl_ff   <= ctrl_in;
         presc_ff  <= presc_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/cascaded_prescaled_timer_unit.sv =====
// Top level of the cascaded prescaled timer unit: request register, timer
// channels, result register. Depends on cptu_pkg and cptu_timer.
//
//  channel  direction  handshake             payload
//  req      in         req_valid/req_ready   action, timer_select, write_data
//  rsp      out        rsp_valid/rsp_ready   read_data, irq_pulse, overflow_flags
//
// One request per clock sustained while rsp_ready is held; a request passes the
// request register, then the timer update and result register in the same edge.
// The cascade ripple through NUM_TIMERS channels sets the longest path.
// Synchronous reset clears all timer state and both pipeline valids.
// A stalled result holds its register; the request register still takes one
// new transfer while the result waits.
`default_nettype none

module cascaded_prescaled_timer_unit #(
   parameter int NUM_TIMERS = cptu_pkg::NUM_TIMERS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_action,
   input  wire logic [cptu_pkg::SEL_W-1:0]    req_timer_select,
   input  wire logic [cptu_pkg::CNT_W-1:0]    req_write_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [cptu_pkg::CNT_W-1:0]         rsp_read_data,
   output logic [cptu_pkg::FLAG_W-1:0]        rsp_irq_pulse,
   output logic [cptu_pkg::FLAG_W-1:0]        rsp_overflow_flags
);

   // Request register
   logic                         in_valid_ff, in_valid_in;
   cptu_pkg::action_type         action_ff;
   logic [cptu_pkg::SEL_W-1:0]   sel_ff;
   logic [cptu_pkg::CNT_W-1:0]   data_ff;

   // Result register
   logic                         out_valid_ff, out_valid_in;
   logic [cptu_pkg::CNT_W-1:0]   rd_ff, rd_in;
   logic [cptu_pkg::FLAG_W-1:0]  irq_ff, irq_in;
   logic [cptu_pkg::FLAG_W-1:0]  ovf_ff, ovf_in;

   logic advance;
   logic sel_ok;

   cptu_pkg::timer_cmd_type      cmd    [NUM_TIMERS];
   logic [cptu_pkg::CNT_W-1:0]   count  [NUM_TIMERS];
   logic [NUM_TIMERS-1:0]        ovf_vec;
   logic [NUM_TIMERS-1:0]        irq_vec;

   // Flow control
   assign advance     = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;
   assign out_valid_in = advance ? 1'b1 : (out_valid_ff && !rsp_ready);
   assign sel_ok      = 32'(sel_ff) < NUM_TIMERS;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         action_ff <= cptu_pkg::action_type'(req_action);
         sel_ff    <= req_timer_select;
         data_ff   <= req_write_data;
      end
      if (advance) begin
         rd_ff  <= rd_in;
         irq_ff <= irq_in;
         ovf_ff <= ovf_in;
      end
   end

   // Timer channels with cascade chain
   for (genvar t = 0; t < NUM_TIMERS; t++) begin : g_timer
      logic targeted;
      assign targeted = sel_ok && (32'(sel_ff) == t);
      assign cmd[t].tick       = advance && (action_ff == cptu_pkg::ACT_TICK);
      assign cmd[t].wr_reload  = advance && targeted && (action_ff == cptu_pkg::ACT_WR_RELOAD);
      assign cmd[t].wr_control = advance && targeted
                                 && (action_ff == cptu_pkg::ACT_WR_CONTROL);
      cptu_timer u_timer (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd[t]),
         .write_data (data_ff),
         .chain_en   (t > 0),
         .chain_in   ((t > 0) ? ovf_vec[(t > 0) ? t - 1 : 0] : 1'b0),
         .overflow   (ovf_vec[t]),
         .irq        (irq_vec[t]),
         .count      (count[t])
      );
   end

   // Result assembly
   always_comb begin
      rd_in  = '0;
      irq_in = '0;
      ovf_in = '0;
      for (int t = 0; t < NUM_TIMERS; t++) begin
         if (t < cptu_pkg::FLAG_W) begin
            irq_in[t % cptu_pkg::FLAG_W] = irq_vec[t];
            ovf_in[t % cptu_pkg::FLAG_W] = ovf_vec[t];
         end
         if ((action_ff == cptu_pkg::ACT_RD_COUNTER) && (32'(sel_ff) == t)) begin
            rd_in = count[t];
         end
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_read_data      = rd_ff;
   assign rsp_irq_pulse      = irq_ff;
   assign rsp_overflow_flags = ovf_ff;

endmodule

`default_nettype wire
